// ===== rtl/utf8_missing_glyph_tracker_assert.svh =====
`ifndef UTF8_MISSING_GLYPH_TRACKER_ASSERT_SVH
`define UTF8_MISSING_GLYPH_TRACKER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define UMGT_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define UMGT_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/umgt_pkg.sv =====
package umgt_pkg;

    // Field widths fixed by the item format.
    localparam int POINT_W    = 21;
    localparam int BASIC_W    = 16;
    localparam int WORD_IDX_W = 16;
    localparam int BIT_IDX_W  = 6;

    // Largest code point of the basic plane.
    localparam logic [POINT_W-1:0] BASIC_MAX = 21'h00FFFF;

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // Action codes of an input item.
    localparam logic [1:0] ACT_TEXT  = 2'd0;
    localparam logic [1:0] ACT_HOOK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         byte0;
        logic [7:0]         byte1;
        logic [7:0]         byte2;
        logic [7:0]         byte3;
        logic [2:0]         bytes_left;
        logic               glyph_present;
        logic [POINT_W-1:0] reported_point;
    } umgt_item_t;

    typedef struct packed {
        logic [2:0]         bytes_consumed;
        logic [POINT_W-1:0] decoded_point;
        logic               newly_missing;
        logic [16:0]        distinct_missing;
        logic [31:0]        total_missing;
        logic [31:0]        non_basic_count;
    } umgt_result_t;

    // Work the back end does for one item.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_NON_BASIC,
        OP_TEXT_MARK,
        OP_HOOK_MARK
    } umgt_op_kind_t;

    typedef struct packed {
        umgt_op_kind_t         kind;
        logic                  glyph_present;
        logic [2:0]            bytes_consumed;
        logic [POINT_W-1:0]    point;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [BIT_IDX_W-1:0]  bit_idx;
    } umgt_op_t;

    typedef struct packed {
        logic pop;
        logic init_sweep;
    } umgt_back_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } umgt_back_state_t;

endpackage

// ===== rtl/umgt_front.sv =====
module umgt_front #(
    parameter int TRACKED_POINTS = 65536,
    parameter int MAP_WORD_BITS  = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  umgt_pkg::umgt_item_t       item,
    input  umgt_pkg::umgt_back_status_t back_status,
    output logic                       busy,
    output logic                       push,
    output umgt_pkg::umgt_op_t         push_op
);
    import umgt_pkg::*;

    // Reciprocals for the two divisions by constants (floor of 2^32 / d).
    localparam int RT_W = 33 - $clog2(TRACKED_POINTS);
    localparam int RW_W = 33 - $clog2(MAP_WORD_BITS);
    localparam logic [63:0] RECIP_T_FULL = 64'h1_0000_0000 / 64'(TRACKED_POINTS);
    localparam logic [63:0] RECIP_W_FULL = 64'h1_0000_0000 / 64'(MAP_WORD_BITS);
    localparam logic [RT_W-1:0] RECIP_T = RT_W'(RECIP_T_FULL);
    localparam logic [RW_W-1:0] RECIP_W = RW_W'(RECIP_W_FULL);
    localparam int P1_W = BASIC_W + RT_W;
    localparam int P2_W = BASIC_W + RW_W;

    logic               accept;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [2:0]         left;
    logic               c1_ok, c2_ok, c3_ok;
    logic [POINT_W-1:0] dec_point;
    logic [2:0]         dec_len;
    umgt_op_t           in_op;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    umgt_op_t           s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic [BASIC_W-1:0] s2_q1_reg, s3_p_reg, s4_p_reg, s4_q2_reg;
    logic [BASIC_W-1:0] q1_next, p_next, q2_next;
    logic [P1_W-1:0]    q1_prod;
    logic [P2_W-1:0]    q2_prod;
    logic [33:0]        qt_prod, r_full;
    logic [17:0]        r_part;
    logic [23:0]        wq_prod, b_full;
    logic [7:0]         b_part;
    logic [WORD_IDX_W-1:0] word_sel;

    // Items are accepted while a queue slot can be reserved and no reset sweep runs.
    assign busy   = (occ_reg == OCC_W'(QUEUE_DEPTH)) || back_status.init_sweep;
    assign accept = start && !busy;
    assign occ_next = occ_reg + OCC_W'(accept) - OCC_W'(back_status.pop);

    // UTF-8 decode of the byte window.
    always_comb
    begin
        left      = (item.bytes_left > 3'd4) ? 3'd4 : item.bytes_left;
        c1_ok     = (item.byte1[7:6] == 2'b10);
        c2_ok     = (item.byte2[7:6] == 2'b10);
        c3_ok     = (item.byte3[7:6] == 2'b10);
        dec_point = '0;
        dec_len   = 3'd1;
        if (!item.byte0[7])
        begin
            dec_point = {13'd0, item.byte0};
        end
        else if (item.byte0[7:5] == 3'b110)
        begin
            if (left >= 3'd2 && c1_ok)
            begin
                dec_point = {10'd0, item.byte0[4:0], item.byte1[5:0]};
                dec_len   = 3'd2;
            end
        end
        else if (item.byte0[7:4] == 4'b1110)
        begin
            if (left >= 3'd3 && c1_ok && c2_ok)
            begin
                dec_point = {5'd0, item.byte0[3:0], item.byte1[5:0], item.byte2[5:0]};
                dec_len   = 3'd3;
            end
        end
        else if (item.byte0[7:3] == 5'b11110)
        begin
            if (left == 3'd4 && c1_ok && c2_ok && c3_ok)
            begin
                dec_point = {item.byte0[2:0], item.byte1[5:0], item.byte2[5:0],
                             item.byte3[5:0]};
                dec_len   = 3'd4;
            end
        end
    end

    // Classify the item into the work the back end has to do.
    always_comb
    begin
        in_op = '0;
        in_op.glyph_present = item.glyph_present;
        case (item.action)
            ACT_TEXT:
            begin
                if (left != 3'd0)
                begin
                    in_op.bytes_consumed = dec_len;
                    in_op.point          = dec_point;
                    in_op.kind = (dec_point > BASIC_MAX) ? OP_NON_BASIC : OP_TEXT_MARK;
                end
            end
            ACT_HOOK:
            begin
                in_op.point = item.reported_point;
                in_op.kind  = (item.reported_point > BASIC_MAX) ? OP_NON_BASIC : OP_HOOK_MARK;
            end
            ACT_CLEAR:
            begin
                in_op.kind = OP_CLEAR;
            end
            default:
            begin
                in_op.kind = OP_NONE;
            end
        endcase
    end

    // Bitmap address: point modulo TRACKED_POINTS, then word and bit within word.
    always_comb
    begin
        q1_prod = P1_W'(s1_op_reg.point[BASIC_W-1:0]) * P1_W'(RECIP_T);
        q1_next = BASIC_W'(q1_prod >> 32);

        qt_prod = 34'(s2_q1_reg) * 34'(TRACKED_POINTS);
        r_full  = 34'(s2_op_reg.point[BASIC_W-1:0]) - qt_prod;
        r_part  = r_full[17:0];
        if (r_part >= 18'(TRACKED_POINTS))
        begin
            r_part = r_part - 18'(TRACKED_POINTS);
        end
        p_next = r_part[BASIC_W-1:0];

        q2_prod = P2_W'(s3_p_reg) * P2_W'(RECIP_W);
        q2_next = BASIC_W'(q2_prod >> 32);

        wq_prod  = 24'(s4_q2_reg) * 24'(MAP_WORD_BITS);
        b_full   = 24'(s4_p_reg) - wq_prod;
        b_part   = b_full[7:0];
        word_sel = WORD_IDX_W'(s4_q2_reg);
        if (b_part >= 8'(MAP_WORD_BITS))
        begin
            b_part   = b_part - 8'(MAP_WORD_BITS);
            word_sel = word_sel + 16'd1;
        end
    end

    // Queue write from the last stage.
    always_comb
    begin
        push_op          = s4_op_reg;
        push_op.word_idx = word_sel;
        push_op.bit_idx  = b_part[BIT_IDX_W-1:0];
    end
    assign push = s4_valid_reg;

    // Stage valid bits and slot count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= in_op;
        end
        s2_op_reg <= s1_op_reg;
        s2_q1_reg <= q1_next;
        s3_op_reg <= s2_op_reg;
        s3_p_reg  <= p_next;
        s4_op_reg <= s3_op_reg;
        s4_p_reg  <= s3_p_reg;
        s4_q2_reg <= q2_next;
    end

endmodule

// ===== rtl/umgt_queue.sv =====
module umgt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  umgt_pkg::umgt_op_t push_op,
    input  logic               pop,
    output logic               head_valid,
    output umgt_pkg::umgt_op_t head
);
    import umgt_pkg::*;

    `include "utf8_missing_glyph_tracker_assert.svh"

    umgt_op_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]  count_reg, count_next;
    logic              full;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == OCC_W'(QUEUE_DEPTH));
    assign head       = entries[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

    // The front end's slot reservation must keep the queue from overflowing.
    `UMGT_ASSERT(a_no_push_when_full, !(push && full && !pop), "queue overflow")
    `UMGT_ASSERT(a_no_pop_when_empty, !(pop && !head_valid), "queue underflow")
    `UMGT_ASSERT_NEXT(a_count_tracks, push && !pop && !full, count_reg == $past(count_reg) + 1'b1, "queue count did not advance on push")

endmodule

// ===== rtl/umgt_back.sv =====
module umgt_back #(
    parameter int TRACKED_POINTS = 65536,
    parameter int MAP_WORD_BITS  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  umgt_pkg::umgt_op_t          head,
    output umgt_pkg::umgt_back_status_t status,
    output logic                        result_valid,
    output umgt_pkg::umgt_result_t      result
);
    import umgt_pkg::*;

    `include "utf8_missing_glyph_tracker_assert.svh"

    localparam int WORDS = (TRACKED_POINTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W  = $clog2(WORDS);
    localparam int BIT_W = $clog2(MAP_WORD_BITS);

    umgt_back_state_t   state_reg, state_next;
    logic [WA_W-1:0]    sweep_reg, sweep_next;
    logic               init_reg, init_next;
    umgt_op_t           op_reg;
    logic [MAP_WORD_BITS-1:0] map_mem [WORDS];
    logic [MAP_WORD_BITS-1:0] map_rdata_reg;
    logic [16:0]        distinct_reg, distinct_next;
    logic [31:0]        total_reg, total_next;
    logic [31:0]        nb_reg, nb_next;
    umgt_result_t       result_reg, result_next;
    logic               result_valid_reg, result_valid_next;
    logic               pop;
    logic               hit;
    logic               fresh;
    logic               mem_we;
    logic [WA_W-1:0]    mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [BIT_W-1:0]   bit_sel;

    assign status.pop        = pop;
    assign status.init_sweep = init_reg;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;
    assign bit_sel           = op_reg.bit_idx[BIT_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.kind == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (sweep_reg == WA_W'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath controls: bitmap update, counters and result.
    always_comb
    begin
        pop               = 1'b0;
        hit               = 1'b0;
        fresh             = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = sweep_reg;
        mem_wdata         = '0;
        sweep_next        = sweep_reg;
        init_next         = init_reg;
        distinct_next     = distinct_reg;
        total_next        = total_reg;
        nb_next           = nb_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop        = head_valid;
                sweep_next = '0;
            end
            ST_EXEC:
            begin
                hit       = map_rdata_reg[bit_sel];
                mem_waddr = op_reg.word_idx[WA_W-1:0];
                mem_wdata = map_rdata_reg;
                mem_wdata[bit_sel] = 1'b1;
                case (op_reg.kind)
                    OP_NON_BASIC:
                    begin
                        total_next = total_reg + 32'd1;
                        nb_next    = nb_reg + 32'd1;
                    end
                    OP_TEXT_MARK:
                    begin
                        if (!hit)
                        begin
                            mem_we = 1'b1;
                            if (!op_reg.glyph_present)
                            begin
                                total_next    = total_reg + 32'd1;
                                distinct_next = distinct_reg + 17'd1;
                                fresh         = 1'b1;
                            end
                        end
                    end
                    OP_HOOK_MARK:
                    begin
                        total_next = total_reg + 32'd1;
                        if (!hit)
                        begin
                            mem_we        = 1'b1;
                            distinct_next = distinct_reg + 17'd1;
                            fresh         = 1'b1;
                        end
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                result_next.bytes_consumed   = op_reg.bytes_consumed;
                result_next.decoded_point    = op_reg.point;
                result_next.newly_missing    = fresh;
                result_next.distinct_missing = distinct_next;
                result_next.total_missing    = total_next;
                result_next.non_basic_count  = nb_next;
                result_valid_next            = 1'b1;
            end
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                sweep_next    = sweep_reg + 1'b1;
                distinct_next = '0;
                total_next    = '0;
                nb_next       = '0;
                if (sweep_reg == WA_W'(WORDS - 1))
                begin
                    init_next         = 1'b0;
                    result_next       = '0;
                    result_valid_next = !init_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sweep_reg        <= '0;
            init_reg         <= 1'b1;
            distinct_reg     <= '0;
            total_reg        <= '0;
            nb_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            init_reg         <= init_next;
            distinct_reg     <= distinct_next;
            total_reg        <= total_next;
            nb_reg           <= nb_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head;
        end
        result_reg <= result_next;
    end

    // Judged bitmap: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        map_rdata_reg <= map_mem[head.word_idx[WA_W-1:0]];
    end

    `UMGT_ASSERT(a_result_source, !result_valid_reg || $past(state_reg) == ST_EXEC || $past(state_reg) == ST_CLEAR, "result without finished work")
    `UMGT_ASSERT(a_fresh_is_basic, !(result_valid_reg && result_reg.newly_missing) || result_reg.decoded_point <= BASIC_MAX, "newly missing point above basic plane")
    `UMGT_ASSERT(a_quiet_init, !(init_reg && result_valid_reg), "result during reset sweep")
    `UMGT_ASSERT_NEXT(a_pop_starts_work, pop, state_reg == ST_EXEC || state_reg == ST_CLEAR, "popped item not executed")

endmodule

// ===== rtl/utf8_missing_glyph_tracker.sv =====
// UTF-8 missing glyph tracker.
// Input channel: an item (action, byte window, glyph flag, reported point) is
// taken at a rising clock edge where start is high and busy is low.
// Output channel: each item yields exactly one result, shown on result for a
// single cycle with result_valid high; the receiver cannot stall it.
// The front end decodes and classifies items in a four-stage pipeline and
// computes the bitmap word and bit; up to 8 items may be in flight between
// acceptance and execution, and busy rises when all 8 slots are taken.
// The back end does one bitmap read-modify-write per item: it pops the item
// in its idle state and updates the bitmap in its exec state, so it takes no
// new item before the last one is done. A text or hook item passes the four
// front-end stages, the queue and the idle and exec states on its way to result.
// A clear action sweeps every bitmap word, one per cycle (1024 words at the
// default sizes), then returns a result with all counters zero.
// After reset the same sweep runs once with busy held high and no result,
// so the block takes its first item only once the sweep has cleared every word.
module utf8_missing_glyph_tracker #(
    parameter int TRACKED_POINTS = 65536,
    parameter int MAP_WORD_BITS  = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  umgt_pkg::umgt_item_t   item,
    output logic                   result_valid,
    output umgt_pkg::umgt_result_t result
);
    import umgt_pkg::*;

    logic              push;
    umgt_op_t          push_op;
    logic              head_valid;
    umgt_op_t          head;
    umgt_back_status_t back_status;

    // Decode and classification.
    umgt_front #(
        .TRACKED_POINTS (TRACKED_POINTS),
        .MAP_WORD_BITS  (MAP_WORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .back_status (back_status),
        .busy        (busy),
        .push        (push),
        .push_op     (push_op)
    );

    // Work queue between the two ends.
    umgt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (back_status.pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Bitmap and counters.
    umgt_back #(
        .TRACKED_POINTS (TRACKED_POINTS),
        .MAP_WORD_BITS  (MAP_WORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .status       (back_status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
